FILE: rtl/dpd_pkg.sv
`default_nettype none

package dpd_pkg;

  // Field widths
  localparam int VALUE_W = 31;
  localparam int DIFF_W  = 4;
  localparam int DIG_W   = 4;

  // Configuration port
  localparam int CFG_W   = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register index of max_difference
  localparam int REG_MAX_DIFFERENCE = 0;

  // Number of low decimal digits taken from value
  localparam int DIGITS_DEFAULT = 10;

  // Divide by ten: q = (v * DIV10_MAGIC) >> DIV10_SHIFT, exact for v < 2**32
  localparam int          MAGIC_W     = 32;
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  // The balanced split lies within this many steps below half the digit sum
  localparam int WIN_W = 5;

endpackage

`default_nettype wire

FILE: rtl/digit_partition_difference.sv
`default_nettype none

// Channel     Signals                               Direction  Meaning
// ---------   -----------------------------------   ---------  -------------------------------
// value       value_valid, value_ready, value       in         one number per transfer
// result      result_valid, result_ready,           out        difference, qualifies per number
//             difference, qualifies
// config      psel, penable, pwrite, paddr,         in/out     max_difference at byte address 0
//             pwdata, prdata, pready
//
// One number enters per cycle while the result channel is not stalled.
// Stage k peels decimal digit k-1 off with one 31x32 reciprocal multiply and folds the
// previous digit into the reachable-sum bitset; three stages then finish the partition.
// Reset (rst, synchronous) clears max_difference and all valid bits.
// A stall on the result channel holds every stage; no transfer is lost or repeated.

module digit_partition_difference #(
  parameter int DIGITS = dpd_pkg::DIGITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,

  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dpd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [dpd_pkg::PDATA_W-1:0]  pwdata,
  output logic      [dpd_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,

  input  wire logic                         value_valid,
  output logic                              value_ready,
  input  wire logic [dpd_pkg::VALUE_W-1:0]  value,

  output logic                              result_valid,
  input  wire logic                         result_ready,
  output logic      [dpd_pkg::DIFF_W-1:0]   difference,
  output logic                              qualifies
);

  import dpd_pkg::*;

  localparam int MAX_SUM   = 9 * DIGITS;
  localparam int REACH_W   = MAX_SUM + 1;
  localparam int TOTAL_W   = $clog2(MAX_SUM + 1);
  localparam int EXT_W     = REACH_W + WIN_W - 1;
  localparam int EXT_IDX_W = $clog2(EXT_W);
  localparam int OFF_W     = $clog2(WIN_W);
  localparam int PROD_W    = VALUE_W + MAGIC_W;

  // Configuration register
  logic [CFG_W-1:0] max_difference;
  logic             cfg_write;
  logic             cfg_hit;

  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_MAX_DIFFERENCE));
  assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
  assign prdata    = cfg_hit ? PDATA_W'(max_difference) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_difference <= '0;
    end else if (cfg_write) begin
      max_difference <= pwdata[CFG_W-1:0];
    end
  end

  // Whole pipeline moves together; the output register decouples the result side
  logic advance;

  assign advance     = !result_valid || result_ready;
  assign value_ready = advance;

  // Digit stages: entry 0 is the input register
  logic [VALUE_W-1:0] quo   [0:DIGITS];
  logic [DIG_W-1:0]   dig   [0:DIGITS];
  logic [REACH_W-1:0] reach [0:DIGITS];
  logic [TOTAL_W-1:0] total [0:DIGITS];
  logic               vld   [0:DIGITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (advance) begin
      vld[0] <= value_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      quo[0]   <= value;
      dig[0]   <= '0;
      reach[0] <= REACH_W'(1);
      total[0] <= '0;
    end
  end

  for (genvar k = 1; k <= DIGITS; k++) begin : g_digit
    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] q;
    logic [VALUE_W-1:0] rem;

    assign prod = PROD_W'(quo[k-1]) * PROD_W'(DIV10_MAGIC);
    assign q    = VALUE_W'(prod >> DIV10_SHIFT);
    assign rem  = quo[k-1] - ((q << 3) + (q << 1));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (advance) begin
        vld[k] <= vld[k-1];
      end
    end

    // Split off digit k-1 and fold the previous stage's digit into the bitset
    always_ff @(posedge clk) begin
      if (advance) begin
        quo[k]   <= q;
        dig[k]   <= rem[DIG_W-1:0];
        reach[k] <= reach[k-1] | (reach[k-1] << dig[k-1]);
        total[k] <= total[k-1] + TOTAL_W'(dig[k-1]);
      end
    end
  end

  // Fold in the last digit
  logic [REACH_W-1:0] reach_f;
  logic [TOTAL_W-1:0] total_f;
  logic               vld_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_f <= 1'b0;
    end else if (advance) begin
      vld_f <= vld[DIGITS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      reach_f <= reach[DIGITS] | (reach[DIGITS] << dig[DIGITS]);
      total_f <= total[DIGITS] + TOTAL_W'(dig[DIGITS]);
    end
  end

  // Take the window of reachable sums just at and below half the total.
  // win[WIN_W-1] is sum cap, win[0] is cap - (WIN_W-1); sums below zero read as 0.
  logic [EXT_W-1:0]     reach_ext;
  logic [EXT_IDX_W-1:0] cap;
  logic [WIN_W-1:0]     win;
  logic                 parity;
  logic                 vld_w;

  assign reach_ext = {reach_f, (WIN_W-1)'(0)};
  assign cap       = EXT_IDX_W'(total_f >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_w <= 1'b0;
    end else if (advance) begin
      vld_w <= vld_f;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      win    <= reach_ext[cap +: WIN_W];
      parity <= total_f[0];
    end
  end

  // Difference = (total - 2*cap) + 2*(cap - best)
  logic [OFF_W-1:0]  off;
  logic [DIFF_W-1:0] diff_next;

  always_comb begin
    off = OFF_W'(WIN_W - 1);
    for (int j = 0; j < WIN_W; j++) begin
      if (win[j]) begin
        off = OFF_W'(WIN_W - 1 - j);
      end
    end
    diff_next = DIFF_W'({off, 1'b0}) + DIFF_W'(parity);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= vld_w;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      difference <= diff_next;
      qualifies  <= (diff_next <= max_difference);
    end
  end

endmodule

`default_nettype wire
